// ===== hdl/mbrptc_pkg.sv =====
// Shared types and constants for the partition table checker.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mbrptc_pkg;

   localparam int TABLE_OFFSET        = 446;
   localparam int ENTRY_SIZE          = 16;
   localparam int DEFAULT_ENTRY_COUNT = 4;
   localparam int DEFAULT_QUEUE_DEPTH = 2;
   localparam int RSP_DATA_WIDTH      = 72;

   localparam logic [8:0] POS_FIRST    = 9'd0;
   localparam logic [8:0] SIG_LOW_POS  = 9'd510;
   localparam logic [8:0] SIG_HIGH_POS = 9'd511;
   localparam logic [7:0] SIG_LOW_BYTE  = 8'h55;
   localparam logic [7:0] SIG_HIGH_BYTE = 8'hAA;

   localparam int ACTIVE_BIT = 7;

   localparam logic [10:0] CYLINDER_COUNT_RESET    = 11'd1024;
   localparam logic [8:0]  HEAD_COUNT_RESET        = 9'd255;
   localparam logic [5:0]  SECTORS_PER_TRACK_RESET = 6'd63;

   localparam logic [1:0] REG_CYLINDER_COUNT    = 2'd0;
   localparam logic [1:0] REG_HEAD_COUNT        = 2'd1;
   localparam logic [1:0] REG_SECTORS_PER_TRACK = 2'd2;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_ENTRY  = 2'd1,
      CMD_FINISH = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [1:0]        index;
      logic              sig_valid;
      logic [15:0][7:0]  bytes;
   } cmd_type;

   typedef struct packed {
      logic [10:0] cylinder_count;
      logic [8:0]  head_count;
      logic [5:0]  sectors_per_track;
   } geom_type;

endpackage

`default_nettype wire

// ===== hdl/mbrptc_front.sv =====
// Front end: tracks the byte offset, captures entry bytes and the signature,
// and queues clear, entry and finish commands. Depends on mbrptc_pkg.
`default_nettype none

module mbrptc_front #(
   parameter int ENTRY_COUNT = mbrptc_pkg::DEFAULT_ENTRY_COUNT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,   // [7:0] sector_byte
   input  wire logic              req_tuser,   // [0] first_of_sector
   output logic                   push_valid,
   output mbrptc_pkg::cmd_type    push_data,
   input  wire logic              queue_full
);

   localparam int TABLE_END = mbrptc_pkg::TABLE_OFFSET + mbrptc_pkg::ENTRY_SIZE * ENTRY_COUNT;
   localparam int LAST_OFF  = mbrptc_pkg::ENTRY_SIZE - 1;

   logic [8:0] pos_ff, pos_in;
   logic       sig_low_ff, sig_low_in;
   logic [7:0] entry_ff [LAST_OFF];

   logic       accept;
   logic [8:0] pos;
   logic [8:0] rel;
   logic [3:0] off;
   logic       in_table;
   logic       entry_end;

   always_comb begin
      req_tready = !queue_full;
      accept     = req_tvalid && req_tready;
      pos        = req_tuser ? mbrptc_pkg::POS_FIRST : pos_ff;
      rel        = pos - 9'(mbrptc_pkg::TABLE_OFFSET);
      off        = rel[3:0];
      in_table   = ({1'b0, pos} >= 10'(mbrptc_pkg::TABLE_OFFSET)) &&
                   ({1'b0, pos} < 10'(TABLE_END));
      entry_end  = in_table && (off == 4'(LAST_OFF));

      pos_in     = pos_ff;
      sig_low_in = sig_low_ff;
      if (accept) begin
         pos_in = pos + 9'd1;
         if (pos == mbrptc_pkg::POS_FIRST) begin
            sig_low_in = 1'b0;
         end else if (pos == mbrptc_pkg::SIG_LOW_POS) begin
            sig_low_in = (req_tdata == mbrptc_pkg::SIG_LOW_BYTE);
         end
      end

      push_valid = accept && ((pos == mbrptc_pkg::POS_FIRST) || entry_end ||
                              (pos == mbrptc_pkg::SIG_HIGH_POS));
      push_data.index     = rel[5:4];
      push_data.sig_valid = sig_low_ff && (req_tdata == mbrptc_pkg::SIG_HIGH_BYTE);
      for (int k = 0; k < LAST_OFF; k++) begin
         push_data.bytes[k] = entry_ff[k];
      end
      push_data.bytes[LAST_OFF] = req_tdata;
      if (pos == mbrptc_pkg::POS_FIRST) begin
         push_data.kind = mbrptc_pkg::CMD_CLEAR;
      end else if (entry_end) begin
         push_data.kind = mbrptc_pkg::CMD_ENTRY;
      end else begin
         push_data.kind = mbrptc_pkg::CMD_FINISH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= mbrptc_pkg::POS_FIRST;
         sig_low_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         sig_low_ff <= sig_low_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && in_table && !entry_end) begin
         entry_ff[off] <= req_tdata;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/mbrptc_queue.sv =====
// Short command queue between the front end and the checking back end.
// Depends on mbrptc_pkg for the command type.
`default_nettype none

module mbrptc_queue #(
   parameter int DEPTH = mbrptc_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   input  wire mbrptc_pkg::cmd_type  push_data,
   output logic                      full,
   input  wire logic                 pop,
   output mbrptc_pkg::cmd_type       pop_data,
   output logic                      empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   mbrptc_pkg::cmd_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   always_comb begin
      full     = (count_ff == CW'(DEPTH));
      empty    = (count_ff == '0);
      do_push  = push_valid && !full;
      do_pop   = pop && !empty;
      pop_data = slot_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/mbrptc_back.sv =====
// Back end: checks each queued entry against the geometry through ST_MUL_A, ST_MUL_B and ST_CHECK,
// keeps per-entry results and emits one result word per entry. Depends on mbrptc_pkg.
`default_nettype none

module mbrptc_back #(
   parameter int ENTRY_COUNT = mbrptc_pkg::DEFAULT_ENTRY_COUNT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mbrptc_pkg::geom_type geom,
   input  wire logic                 queue_empty,
   input  wire mbrptc_pkg::cmd_type  queue_data,
   output logic                      queue_pop,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [mbrptc_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // [0] table_valid, [1] entry_accepted, [33:2] start_sector,
   // [65:34] block_total, [66] several_active, [71:67] zero
   output logic [1:0]                rsp_tuser,   // [1:0] entry_index
   output logic                      rsp_tlast
);

   localparam int IW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MUL_A = 5'b00010,
      ST_MUL_B = 5'b00100,
      ST_CHECK = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic        ok_ff    [ENTRY_COUNT];
   logic        ok_in    [ENTRY_COUNT];
   logic [31:0] start_ff [ENTRY_COUNT];
   logic [31:0] start_in [ENTRY_COUNT];
   logic [31:0] len_ff   [ENTRY_COUNT];
   logic [31:0] len_in   [ENTRY_COUNT];
   logic [2:0]  active_ff, active_in;
   logic        valid_ff, valid_in;
   logic [1:0]  emit_ff, emit_in;
   logic        out_valid_ff, out_valid_in;
   logic [mbrptc_pkg::RSP_DATA_WIDTH-1:0] out_data_ff, out_data_in;
   logic [1:0]  out_index_ff, out_index_in;
   logic        out_last_ff, out_last_in;

   mbrptc_pkg::cmd_type cur_ff;
   logic [19:0] ps_s_ff, ps_e_ff;
   logic [31:0] lba_s_ff, lba_e_ff;

   logic [9:0]  sc, ec;
   logic [7:0]  sh, eh;
   logic [5:0]  ss, es;
   logic [31:0] rel, tot;
   logic [25:0] prod_s, prod_e;
   logic        bounds_ok, entry_ok;
   logic        out_free, acc, many;
   logic [IW-1:0] cur_idx, emit_idx;

   always_comb begin
      sc  = {cur_ff.bytes[2][7:6], cur_ff.bytes[3]};
      sh  = cur_ff.bytes[1];
      ss  = cur_ff.bytes[2][5:0];
      ec  = {cur_ff.bytes[6][7:6], cur_ff.bytes[7]};
      eh  = cur_ff.bytes[5];
      es  = cur_ff.bytes[6][5:0];
      rel = {cur_ff.bytes[11], cur_ff.bytes[10], cur_ff.bytes[9], cur_ff.bytes[8]};
      tot = {cur_ff.bytes[15], cur_ff.bytes[14], cur_ff.bytes[13], cur_ff.bytes[12]};
      prod_s = 26'(ps_s_ff) * 26'(geom.sectors_per_track);
      prod_e = 26'(ps_e_ff) * 26'(geom.sectors_per_track);
      bounds_ok = ({1'b0, sc} < geom.cylinder_count) && ({1'b0, ec} < geom.cylinder_count) &&
                  ({1'b0, sh} < geom.head_count) && ({1'b0, eh} < geom.head_count) &&
                  (ss <= geom.sectors_per_track) && (es <= geom.sectors_per_track);
      entry_ok = bounds_ok && (rel == lba_s_ff) && (tot == lba_e_ff - rel + 32'd1);
      cur_idx  = cur_ff.index[IW-1:0];
      emit_idx = emit_ff[IW-1:0];

      out_free = !out_valid_ff || rsp_tready;
      acc      = valid_ff && ok_ff[emit_idx];
      many     = valid_ff && (active_ff > 3'd1);

      state_in     = state_ff;
      ok_in        = ok_ff;
      start_in     = start_ff;
      len_in       = len_ff;
      active_in    = active_ff;
      valid_in     = valid_ff;
      emit_in      = emit_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_index_in = out_index_ff;
      out_last_in  = out_last_ff;
      queue_pop    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               unique case (queue_data.kind)
                  mbrptc_pkg::CMD_CLEAR: begin
                     for (int k = 0; k < ENTRY_COUNT; k++) begin
                        ok_in[k]    = 1'b0;
                        start_in[k] = '0;
                        len_in[k]   = '0;
                     end
                     active_in = '0;
                  end
                  mbrptc_pkg::CMD_ENTRY: begin
                     state_in = ST_MUL_A;
                  end
                  mbrptc_pkg::CMD_FINISH: begin
                     valid_in = queue_data.sig_valid;
                     emit_in  = '0;
                     state_in = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MUL_A: begin
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (cur_ff.bytes[0][mbrptc_pkg::ACTIVE_BIT]) begin
               active_in = active_ff + 3'd1;
            end
            ok_in[cur_idx]    = entry_ok;
            start_in[cur_idx] = entry_ok ? rel : '0;
            len_in[cur_idx]   = entry_ok ? tot : '0;
            state_in          = ST_IDLE;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_index_in = emit_ff;
               out_last_in  = (emit_ff == 2'(ENTRY_COUNT - 1));
               out_data_in  = {5'd0, many,
                               acc ? len_ff[emit_idx] : 32'd0,
                               acc ? start_ff[emit_idx] : 32'd0,
                               acc, valid_ff};
               if (emit_ff == 2'(ENTRY_COUNT - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_in = emit_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_tvalid = out_valid_ff;
      rsp_tdata  = out_data_ff;
      rsp_tuser  = out_index_ff;
      rsp_tlast  = out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         valid_ff     <= 1'b0;
         emit_ff      <= '0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < ENTRY_COUNT; k++) begin
            ok_ff[k]    <= 1'b0;
            start_ff[k] <= '0;
            len_ff[k]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         valid_ff     <= valid_in;
         emit_ff      <= emit_in;
         out_valid_ff <= out_valid_in;
         ok_ff        <= ok_in;
         start_ff     <= start_in;
         len_ff       <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      out_index_ff <= out_index_in;
      out_last_ff  <= out_last_in;
      if (queue_pop) begin
         cur_ff <= queue_data;
      end
      if (state_ff == ST_MUL_A) begin
         ps_s_ff <= 20'(sc) * 20'(geom.head_count) + 20'(sh);
         ps_e_ff <= 20'(ec) * 20'(geom.head_count) + 20'(eh);
      end
      if (state_ff == ST_MUL_B) begin
         lba_s_ff <= 32'(prod_s) + 32'(ss) - 32'd1;
         lba_e_ff <= 32'(prod_e) + 32'(es) - 32'd1;
      end
   end

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> (state_ff == ST_IDLE))
      else $error("queue popped while busy");

   a_last_on_final: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |-> (out_index_ff == 2'(ENTRY_COUNT - 1)))
      else $error("last result flag on wrong entry");

   a_accept_needs_sig: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (!out_data_ff[1] || out_data_ff[0]))
      else $error("entry accepted without signature");

   a_active_bound: assert property (@(posedge clock) disable iff (reset)
      1'b1 |-> (active_ff <= 3'(ENTRY_COUNT)))
      else $error("active count beyond entry count");

endmodule

`default_nettype wire

// ===== hdl/mbr_partition_table_checker_unit.sv =====
// Top level of the partition table checker: geometry registers on the CSR port,
// front end, command queue and back end. Depends on mbrptc_pkg, mbrptc_front,
// mbrptc_queue and mbrptc_back.
//
// Feed the 512 bytes of a boot sector on the req stream, one byte per word;
// req_tuser high marks offset zero, and the offset also wraps after byte 511.
// After byte 511 the rsp stream carries four words, one per table entry, with
// rsp_tlast on the fourth. The first result word is registered once the finish
// command leaves the queue, later when the last entry check is still running,
// and the rest follow one per cycle while rsp_tready is high.
// Bytes are taken one per cycle. Every sixteenth table byte hands an entry to the
// back end, whose shared multiply and compare path runs through ST_MUL_A,
// ST_MUL_B and ST_CHECK; a two-deep command queue absorbs that, so req_tready
// drops only when the queue fills, e.g. while the receiver holds rsp_tready low
// during the four results. Reset clears the offset, the entry results and the
// stream state and sets the geometry to 1024 cylinders, 255 heads and 63 sectors
// per track. Write the geometry registers only while no sector is in flight.
`default_nettype none

module mbr_partition_table_checker_unit #(
   parameter int ENTRY_COUNT = mbrptc_pkg::DEFAULT_ENTRY_COUNT,
   parameter int QUEUE_DEPTH = mbrptc_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] sector_byte
   input  wire logic        req_tuser,   // [0] first_of_sector
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [mbrptc_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // [0] table_valid, [1] entry_accepted, [33:2] start_sector,
   // [65:34] block_total, [66] several_active, [71:67] zero
   output logic [1:0]       rsp_tuser,   // [1:0] entry_index
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   mbrptc_pkg::geom_type geom_ff, geom_in;
   mbrptc_pkg::cmd_type  push_data, pop_data;
   logic push_valid, queue_full, queue_pop, queue_empty;
   logic csr_write;

   always_comb begin
      csr_pready = 1'b1;
      csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
      geom_in    = geom_ff;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            mbrptc_pkg::REG_CYLINDER_COUNT:    geom_in.cylinder_count    = csr_pwdata[10:0];
            mbrptc_pkg::REG_HEAD_COUNT:        geom_in.head_count        = csr_pwdata[8:0];
            mbrptc_pkg::REG_SECTORS_PER_TRACK: geom_in.sectors_per_track = csr_pwdata[5:0];
            default: begin
               geom_in = geom_ff;
            end
         endcase
      end
      unique case (csr_paddr[3:2])
         mbrptc_pkg::REG_CYLINDER_COUNT:    csr_prdata = {21'd0, geom_ff.cylinder_count};
         mbrptc_pkg::REG_HEAD_COUNT:        csr_prdata = {23'd0, geom_ff.head_count};
         mbrptc_pkg::REG_SECTORS_PER_TRACK: csr_prdata = {26'd0, geom_ff.sectors_per_track};
         default:                           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff.cylinder_count    <= mbrptc_pkg::CYLINDER_COUNT_RESET;
         geom_ff.head_count        <= mbrptc_pkg::HEAD_COUNT_RESET;
         geom_ff.sectors_per_track <= mbrptc_pkg::SECTORS_PER_TRACK_RESET;
      end else begin
         geom_ff <= geom_in;
      end
   end

   mbrptc_front #(
      .ENTRY_COUNT (ENTRY_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   mbrptc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (queue_pop),
      .pop_data   (pop_data),
      .empty      (queue_empty)
   );

   mbrptc_back #(
      .ENTRY_COUNT (ENTRY_COUNT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .geom        (geom_ff),
      .queue_empty (queue_empty),
      .queue_data  (pop_data),
      .queue_pop   (queue_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== tb/sv/tb_mbr_partition_table_checker_unit.sv =====
`timescale 1ns / 100ps
// Self-checking bench for mbr_partition_table_checker_unit: streams boot sectors,
// predicts the four entry results per sector and compares every rsp word.
// Depends on mbrptc_pkg and the block's RTL only.

module tb_mbr_partition_table_checker_unit;

   localparam int IDLE_LIMIT = 8000;
   localparam int LONG_HOLD  = 1500;
   localparam int SETTLE     = 24;

   typedef struct {
      logic [7:0] data;
      logic       first;
   } sector_word_type;

   typedef struct {
      logic [1:0]  entry_index;
      logic        table_valid;
      logic        entry_accepted;
      logic [31:0] start_sector;
      logic [31:0] block_total;
      logic        several_active;
      logic        last_result;
   } entry_result_type;

   typedef logic [15:0][7:0] part_entry_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'd0;
   logic        req_tuser   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [mbrptc_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = 4'd0;
   logic [31:0] csr_pwdata  = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sector_word_type  sector_words[$];
   entry_result_type entry_results_due[$];
   sector_word_type  next_word;
   entry_result_type due_result;
   part_entry_type   table_ents [4];

   // shadow of the block's geometry and parse state
   mbrptc_pkg::geom_type geom = '{mbrptc_pkg::CYLINDER_COUNT_RESET,
                                  mbrptc_pkg::HEAD_COUNT_RESET,
                                  mbrptc_pkg::SECTORS_PER_TRACK_RESET};
   logic [8:0]  parse_pos = 9'd0;
   part_entry_type entry_buf = '0;
   logic        ent_ok    [4] = '{default: 1'b0};
   logic [31:0] ent_start [4] = '{default: 32'd0};
   logic [31:0] ent_len   [4] = '{default: 32'd0};
   logic [2:0]  active_cnt = 3'd0;
   logic        sig_low_ok = 1'b0;

   logic [8:0]  gen_pos = 9'd0;
   int          mismatch_count = 0;
   int          idle_cycles = 0;
   logic        req_fire = 1'b0;
   logic        hold_request = 1'b0;
   logic        hold_done = 1'b0;
   int          hold_left = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          stall_mode = 0;
   int          stall_left = 0;

   mbr_partition_table_checker_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic logic [31:0] chs_lba(logic [31:0] cyl, logic [31:0] head,
                                           logic [31:0] sect);
      logic [31:0] h;
      logic [31:0] s;
      h = 32'(geom.head_count);
      s = 32'(geom.sectors_per_track);
      return cyl * h * s + head * s + sect - 32'd1;
   endfunction

   function automatic void parse_sector_byte(logic [7:0] b, logic first);
      logic [8:0]  rel_off;
      logic [31:0] sc, sh, ss, ec, eh, es, rel, tot;
      logic        ok;
      logic        valid;
      logic        many;
      logic        acc;
      entry_result_type r;
      if (first)
         parse_pos = 9'd0;
      if (parse_pos == mbrptc_pkg::POS_FIRST) begin
         for (int i = 0; i < 4; i++) begin
            ent_ok[i]    = 1'b0;
            ent_start[i] = 32'd0;
            ent_len[i]   = 32'd0;
         end
         active_cnt = 3'd0;
         sig_low_ok = 1'b0;
      end
      if (parse_pos >= mbrptc_pkg::TABLE_OFFSET &&
          parse_pos < mbrptc_pkg::TABLE_OFFSET + mbrptc_pkg::ENTRY_SIZE * 4) begin
         rel_off = 9'(parse_pos - mbrptc_pkg::TABLE_OFFSET);
         entry_buf[rel_off[3:0]] = b;
         if (rel_off[3:0] == 4'hF) begin
            sc  = 32'({entry_buf[2][7:6], entry_buf[3]});
            sh  = 32'(entry_buf[1]);
            ss  = 32'(entry_buf[2][5:0]);
            ec  = 32'({entry_buf[6][7:6], entry_buf[7]});
            eh  = 32'(entry_buf[5]);
            es  = 32'(entry_buf[6][5:0]);
            rel = entry_buf[11:8];
            tot = entry_buf[15:12];
            if (entry_buf[0][mbrptc_pkg::ACTIVE_BIT])
               active_cnt = active_cnt + 3'd1;
            ok = !(sc >= 32'(geom.cylinder_count) || ec >= 32'(geom.cylinder_count) ||
                   sh >= 32'(geom.head_count) || eh >= 32'(geom.head_count) ||
                   ss > 32'(geom.sectors_per_track) || es > 32'(geom.sectors_per_track));
            if (ok && rel != chs_lba(sc, sh, ss))
               ok = 1'b0;
            if (ok && tot != chs_lba(ec, eh, es) - rel + 32'd1)
               ok = 1'b0;
            ent_ok[rel_off[5:4]]    = ok;
            ent_start[rel_off[5:4]] = ok ? rel : 32'd0;
            ent_len[rel_off[5:4]]   = ok ? tot : 32'd0;
         end
      end
      if (parse_pos == mbrptc_pkg::SIG_LOW_POS)
         sig_low_ok = (b == mbrptc_pkg::SIG_LOW_BYTE);
      if (parse_pos == mbrptc_pkg::SIG_HIGH_POS) begin
         valid = sig_low_ok && b == mbrptc_pkg::SIG_HIGH_BYTE;
         many  = valid && active_cnt > 3'd1;
         for (int i = 0; i < 4; i++) begin
            acc = valid && ent_ok[i];
            r.entry_index    = i[1:0];
            r.table_valid    = valid;
            r.entry_accepted = acc;
            r.start_sector   = acc ? ent_start[i] : 32'd0;
            r.block_total    = acc ? ent_len[i] : 32'd0;
            r.several_active = many;
            r.last_result    = (i == 3);
            entry_results_due.push_back(r);
         end
      end
      parse_pos = parse_pos + 9'd1;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic part_entry_type chs_entry(logic [7:0] flag, logic [31:0] sc,
                                                logic [31:0] sh, logic [31:0] ss,
                                                logic [31:0] ec, logic [31:0] eh,
                                                logic [31:0] es, logic [31:0] rel_delta,
                                                logic [31:0] tot_delta);
      part_entry_type e;
      logic [31:0] start_lba;
      start_lba = chs_lba(sc, sh, ss);
      e[0] = flag;
      e[1] = sh[7:0];
      e[2] = {sc[9:8], ss[5:0]};
      e[3] = sc[7:0];
      e[4] = 8'($urandom_range(0, 255));
      e[5] = eh[7:0];
      e[6] = {ec[9:8], es[5:0]};
      e[7] = ec[7:0];
      e[11:8]  = start_lba + rel_delta;
      e[15:12] = chs_lba(ec, eh, es) - start_lba + 32'd1 + tot_delta;
      return e;
   endfunction

   function automatic part_entry_type random_entry(logic active);
      part_entry_type e;
      int          cmax, hmax, smax, fb, fbit;
      logic [31:0] sc, sh, ss, ec, eh, es;
      logic [7:0]  flag;
      cmax = (geom.cylinder_count > 11'd1024) ? 1024 : int'(geom.cylinder_count);
      hmax = (geom.head_count > 9'd256) ? 256 : int'(geom.head_count);
      smax = int'(geom.sectors_per_track);
      flag = 8'($urandom_range(0, 255));
      flag[mbrptc_pkg::ACTIVE_BIT] = active;
      if (cmax == 0 || hmax == 0) begin
         for (int k = 0; k < 16; k++)
            e[k] = 8'($urandom_range(0, 255));
         e[0] = flag;
      end else begin
         sc = ($urandom_range(0, 3) == 0) ? cmax - 1 : $urandom_range(0, cmax - 1);
         ec = ($urandom_range(0, 3) == 0) ? cmax - 1 : $urandom_range(0, cmax - 1);
         sh = ($urandom_range(0, 3) == 0) ? hmax - 1 : $urandom_range(0, hmax - 1);
         eh = ($urandom_range(0, 3) == 0) ? hmax - 1 : $urandom_range(0, hmax - 1);
         ss = (smax == 0 || $urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, smax);
         es = (smax == 0 || $urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, smax);
         e = chs_entry(flag, sc, sh, ss, ec, eh, es, 0, 0);
         if ($urandom_range(0, 4) == 0) begin
            fb   = $urandom_range(0, 15);
            fbit = $urandom_range(0, 7);
            e[fb][fbit] = ~e[fb][fbit];
         end
      end
      return e;
   endfunction

   task automatic push_byte(input logic [7:0] d, input logic first);
      sector_word_type w;
      w.data  = d;
      w.first = first;
      sector_words.push_back(w);
      gen_pos = first ? 9'd1 : gen_pos + 9'd1;
   endtask

   task automatic push_noise(input int len, input logic first_start);
      push_byte(8'($urandom_range(0, 255)), first_start);
      for (int i = 1; i < len; i++)
         push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 49) == 0);
   endtask

   // start on a wrap or with first_of_sector when aligned, else restart with first_of_sector
   task automatic push_sector(input logic [7:0] sig_lo, input logic [7:0] sig_hi);
      logic first;
      first = (gen_pos == 9'd0) ? logic'($urandom_range(0, 1)) : 1'b1;
      push_byte(8'($urandom_range(0, 255)), first);
      for (int i = 1; i < mbrptc_pkg::TABLE_OFFSET; i++)
         push_byte(8'($urandom_range(0, 255)), 1'b0);
      for (int n = 0; n < 4; n++)
         for (int k = 0; k < 16; k++)
            push_byte(table_ents[n][k], 1'b0);
      push_byte(sig_lo, 1'b0);
      push_byte(sig_hi, 1'b0);
   endtask

   task automatic csr_write(input logic [1:0] reg_index, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      case (reg_index)
         mbrptc_pkg::REG_CYLINDER_COUNT:    geom.cylinder_count    = value[10:0];
         mbrptc_pkg::REG_HEAD_COUNT:        geom.head_count        = value[8:0];
         mbrptc_pkg::REG_SECTORS_PER_TRACK: geom.sectors_per_track = value[5:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic wait_idle();
      do
         @(posedge clock);
      while (sector_words.size() != 0 || req_tvalid);
      do
         @(negedge clock);
      while (entry_results_due.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_geometry(input int cyl, input int head, input int spt);
      wait_idle();
      csr_write(mbrptc_pkg::REG_CYLINDER_COUNT, cyl);
      csr_write(mbrptc_pkg::REG_HEAD_COUNT, head);
      csr_write(mbrptc_pkg::REG_SECTORS_PER_TRACK, spt);
      @(posedge clock);
   endtask

   // sender: bursts of words with random gaps, hold until accepted
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fire) begin
      end else if (gap_left > 0) begin
         req_tvalid <= 1'b0;
         gap_left = gap_left - 1;
      end else if (sector_words.size() > 0) begin
         next_word = sector_words.pop_front();
         req_tvalid <= 1'b1;
         req_tdata  <= next_word.data;
         req_tuser  <= next_word.first;
         if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
                                                       : $urandom_range(1, 40);
            gap_left = $urandom_range(1, 6);
         end else begin
            burst_left = burst_left - 1;
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // receiver: own stall pattern, plus one long hold on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_request && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left = LONG_HOLD;
         hold_done = 1'b1;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(4, 80);
         end else begin
            stall_left = stall_left - 1;
         end
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= logic'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready)
            parse_sector_byte(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            if (entry_results_due.size() == 0) begin
               $error("unexpected result word: entry_index %0d", rsp_tuser);
               mismatch_count++;
            end else begin
               due_result = entry_results_due.pop_front();
               check_field("entry_index", 32'(due_result.entry_index), 32'(rsp_tuser));
               check_field("table_valid", 32'(due_result.table_valid), 32'(rsp_tdata[0]));
               check_field("entry_accepted", 32'(due_result.entry_accepted),
                           32'(rsp_tdata[1]));
               check_field("start_sector", due_result.start_sector, rsp_tdata[33:2]);
               check_field("block_total", due_result.block_total, rsp_tdata[65:34]);
               check_field("several_active", 32'(due_result.several_active),
                           32'(rsp_tdata[66]));
               check_field("pad", 32'd0, 32'(rsp_tdata[71:67]));
               check_field("last_result", 32'(due_result.last_result), 32'(rsp_tlast));
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles = idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT)
         @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int kind;
      int sectors;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // largest bounds, smallest CHS, sector zero, all-zero entry
      table_ents[0] = chs_entry(8'h80, 1023, 254, 63, 1023, 254, 63, 0, 0);
      table_ents[1] = chs_entry(8'h80, 0, 0, 1, 0, 0, 1, 0, 0);
      table_ents[2] = chs_entry(8'h00, 5, 3, 0, 9, 2, 0, 0, 0);
      table_ents[3] = '0;
      push_sector(mbrptc_pkg::SIG_LOW_BYTE, mbrptc_pkg::SIG_HIGH_BYTE);
      // four active, bad low signature byte
      for (int n = 0; n < 4; n++)
         table_ents[n] = random_entry(1'b1);
      push_sector(8'h54, mbrptc_pkg::SIG_HIGH_BYTE);
      // head out of range, start and count off by one, bad high signature byte
      table_ents[0] = chs_entry(8'h00, 10, 255, 1, 20, 3, 4, 0, 0);
      table_ents[1] = chs_entry(8'h00, 1, 1, 1, 2, 2, 2, 1, 0);
      table_ents[2] = chs_entry(8'h00, 1, 1, 1, 2, 2, 2, 0, 1);
      table_ents[3] = chs_entry(8'hFF, 7, 7, 7, 8, 8, 8, 0, 0);
      push_sector(mbrptc_pkg::SIG_LOW_BYTE, 8'hAB);
      // restart in the middle of a sector
      push_noise(200, 1'b1);
      table_ents[0] = random_entry(1'b1);
      for (int n = 1; n < 4; n++)
         table_ents[n] = random_entry(1'b0);
      push_sector(mbrptc_pkg::SIG_LOW_BYTE, mbrptc_pkg::SIG_HIGH_BYTE);
      table_ents[0] = '1;
      for (int n = 1; n < 4; n++)
         table_ents[n] = random_entry(logic'($urandom_range(0, 1)));
      push_sector(mbrptc_pkg::SIG_LOW_BYTE, mbrptc_pkg::SIG_HIGH_BYTE);

      for (int phase = 0; phase < 7; phase++) begin
         sectors = 3;
         case (phase)
            0: set_geometry(1, 1, 1);
            1: set_geometry(1024, 256, 63);
            2: begin
               set_geometry(0, 0, 0);
               sectors = 1;
            end
            3: begin
               set_geometry(2047, 511, 0);
               sectors = 1;
            end
            6: set_geometry(int'(mbrptc_pkg::CYLINDER_COUNT_RESET),
                            int'(mbrptc_pkg::HEAD_COUNT_RESET),
                            int'(mbrptc_pkg::SECTORS_PER_TRACK_RESET));
            default: set_geometry($urandom_range(1, 1024), $urandom_range(1, 256),
                                  $urandom_range(1, 63));
         endcase
         if (phase == 1)
            hold_request = 1'b1;
         for (int s = 0; s < sectors; s++) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
               push_noise($urandom_range(1, 300), logic'($urandom_range(0, 1)));
            end else if (kind == 1) begin
               push_noise($urandom_range(400, 509), 1'b1);
            end
            for (int n = 0; n < 4; n++)
               table_ents[n] = random_entry($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 6) == 0)
               push_sector(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            else
               push_sector(mbrptc_pkg::SIG_LOW_BYTE, mbrptc_pkg::SIG_HIGH_BYTE);
         end
      end

      wait_idle();
      if (mismatch_count == 0 && entry_results_due.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
